>>> design/gpf_pkg.sv
// Package with the register map, access codes and decode types of the pad-function block.
`timescale 1ns / 1ps
`default_nettype none

package gpf_pkg;

	// Address layout: bits 13..12 select the port, bits 11..0 the register offset.
	localparam int ADDR_W      = 14;
	localparam int ADDR_OFF_W  = 12;
	localparam int ADDR_PORT_W = ADDR_W - ADDR_OFF_W;
	localparam int DATA_W      = 32;

	typedef logic [ADDR_OFF_W-1:0] offset_t;

	// Base offsets of the four live registers of a port.
	localparam offset_t OFF_INT    = 12'h010;
	localparam offset_t OFF_MSK    = 12'h020;
	localparam offset_t OFF_PAT1   = 12'h030;
	localparam offset_t OFF_PAT0   = 12'h040;
	localparam offset_t OFF_COMMIT = 12'h0F0;

	// Alias displacements for the set and clear views of the shadow registers.
	localparam offset_t ALIAS_SET = 12'h004;
	localparam offset_t ALIAS_CLR = 12'h008;

	// Register numbers inside one port.
	localparam int NUM_REGS = 4;
	typedef logic [1:0] reg_sel_t;
	localparam reg_sel_t REG_INT   = 2'd0;
	localparam reg_sel_t REG_MSK   = 2'd1;
	localparam reg_sel_t REG_PTRN1 = 2'd2;
	localparam reg_sel_t REG_PTRN0 = 2'd3;

	// Decoded access operations.
	typedef logic [2:0] op_t;
	localparam op_t OP_BAD    = 3'd0;
	localparam op_t OP_READ   = 3'd1;
	localparam op_t OP_SET    = 3'd2;
	localparam op_t OP_CLR    = 3'd3;
	localparam op_t OP_COMMIT = 3'd4;

	// Result of the address decode for one transaction.
	typedef struct packed {
		op_t                    op;
		reg_sel_t               reg_sel;
		logic [ADDR_PORT_W-1:0] row;
	} dec_t;

endpackage

`default_nettype wire

>>> design/gpf_req_if.sv
// Request channel interface: one bus access per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface gpf_req_if import gpf_pkg::*;;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, output kind, output address, output write_data, input ready);
	modport sink (input valid, input kind, input address, input write_data, output ready);
	modport monitor (input valid, input ready, input kind, input address, input write_data);
endinterface

`default_nettype wire

>>> design/gpf_rsp_if.sv
// Response channel interface: read data and refusal flag of one access.
`timescale 1ns / 1ps
`default_nettype none

interface gpf_rsp_if import gpf_pkg::*;;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              bad_access;

	modport source (output valid, output read_data, output bad_access, input ready);
	modport sink (input valid, input read_data, input bad_access, output ready);
	modport monitor (input valid, input ready, input read_data, input bad_access);
endinterface

`default_nettype wire

>>> design/gpf_decode.sv
// Address decoder that classifies a bus access and picks the register row it touches.
`timescale 1ns / 1ps
`default_nettype none

module gpf_decode import gpf_pkg::*; #(
	parameter int NUM_PORTS = 4
) (
	input  logic              kind,
	input  logic [ADDR_W-1:0] address,
	input  logic [DATA_W-1:0] write_data,
	output dec_t              dec
);

	offset_t                off;
	logic [ADDR_PORT_W-1:0] port;
	logic                   port_ok;
	logic                   commit_ok;

	assign off       = address[ADDR_OFF_W-1:0];
	assign port      = address[ADDR_W-1:ADDR_OFF_W];
	assign port_ok   = int'(port) < NUM_PORTS;
	assign commit_ok = write_data < DATA_W'(NUM_PORTS);

	// Reads are legal only at base offsets; writes only at aliases and commit.
	always_comb begin
		dec.op      = OP_BAD;
		dec.reg_sel = REG_INT;
		dec.row     = port;
		if (port_ok) begin
			if (!kind) begin
				case (off)
					OFF_INT:  begin dec.op = OP_READ; dec.reg_sel = REG_INT;   end
					OFF_MSK:  begin dec.op = OP_READ; dec.reg_sel = REG_MSK;   end
					OFF_PAT1: begin dec.op = OP_READ; dec.reg_sel = REG_PTRN1; end
					OFF_PAT0: begin dec.op = OP_READ; dec.reg_sel = REG_PTRN0; end
					default:  dec.op = OP_BAD;
				endcase
			end else begin
				case (off)
					OFF_INT + ALIAS_SET:  begin dec.op = OP_SET; dec.reg_sel = REG_INT;   end
					OFF_MSK + ALIAS_SET:  begin dec.op = OP_SET; dec.reg_sel = REG_MSK;   end
					OFF_PAT1 + ALIAS_SET: begin dec.op = OP_SET; dec.reg_sel = REG_PTRN1; end
					OFF_PAT0 + ALIAS_SET: begin dec.op = OP_SET; dec.reg_sel = REG_PTRN0; end
					OFF_INT + ALIAS_CLR:  begin dec.op = OP_CLR; dec.reg_sel = REG_INT;   end
					OFF_MSK + ALIAS_CLR:  begin dec.op = OP_CLR; dec.reg_sel = REG_MSK;   end
					OFF_PAT1 + ALIAS_CLR: begin dec.op = OP_CLR; dec.reg_sel = REG_PTRN1; end
					OFF_PAT0 + ALIAS_CLR: begin dec.op = OP_CLR; dec.reg_sel = REG_PTRN0; end
					OFF_COMMIT: begin
						// The commit names its target port in the data word.
						if (commit_ok) begin
							dec.op  = OP_COMMIT;
							dec.row = write_data[ADDR_PORT_W-1:0];
						end
					end
					default: dec.op = OP_BAD;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> design/gpio_pad_function_port_unit.sv
// Top level of the pad-function register block: decode, execute and response stages.
// Path: a request is held in the decode register, then its response in the response register.
// Throughput: one access per cycle while the sink is ready; the decode register and the response register each hold
// one access, and the live and shadow registers are updated in the execute step.
// Reset: arst_n clears both stages and loads every port with INT 0, MSK and PAT1 all pin bits
// one, PAT0 0 in both the live and the shadow copy; the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module gpio_pad_function_port_unit import gpf_pkg::*; #(
	parameter int NUM_PORTS     = 4,
	parameter int PINS_PER_PORT = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	gpf_req_if.sink   req,
	gpf_rsp_if.source rsp
);

	localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	typedef logic [PINS_PER_PORT-1:0] pins_t;

	dec_t  dec_d;
	dec_t  dec_s1;
	pins_t bits_s1;
	logic  valid_s1;
	logic  adv;

	pins_t live_q   [NUM_PORTS][NUM_REGS];
	pins_t shadow_q [NUM_PORTS][NUM_REGS];

	logic              out_valid_q;
	logic [DATA_W-1:0] read_data_q;
	logic              bad_q;

	logic [PORT_W-1:0] row_idx;
	pins_t             live_val;

	gpf_decode #(
		.NUM_PORTS (NUM_PORTS)
	) u_decode (
		.kind       (req.kind),
		.address    (req.address),
		.write_data (req.write_data),
		.dec        (dec_d)
	);

	// Handshake: the execute step moves when it holds an access and the response register is empty or being taken.
	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	// Decode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			dec_s1  <= dec_d;
			bits_s1 <= req.write_data[PINS_PER_PORT-1:0];
		end
	end

	assign row_idx  = dec_s1.row[PORT_W-1:0];
	assign live_val = live_q[row_idx][dec_s1.reg_sel];

	// Shadow registers take the set and clear alias writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PORTS; p++) begin
				shadow_q[p][REG_INT]   <= '0;
				shadow_q[p][REG_MSK]   <= '1;
				shadow_q[p][REG_PTRN1] <= '1;
				shadow_q[p][REG_PTRN0] <= '0;
			end
		end else if (adv) begin
			case (dec_s1.op)
				OP_SET: shadow_q[row_idx][dec_s1.reg_sel] <=
					shadow_q[row_idx][dec_s1.reg_sel] | bits_s1;
				OP_CLR: shadow_q[row_idx][dec_s1.reg_sel] <=
					shadow_q[row_idx][dec_s1.reg_sel] & ~bits_s1;
				default: ;
			endcase
		end
	end

	// Live registers change only on a commit, all four of a port at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PORTS; p++) begin
				live_q[p][REG_INT]   <= '0;
				live_q[p][REG_MSK]   <= '1;
				live_q[p][REG_PTRN1] <= '1;
				live_q[p][REG_PTRN0] <= '0;
			end
		end else if (adv) begin
			case (dec_s1.op)
				OP_COMMIT: begin
					for (int r = 0; r < NUM_REGS; r++) begin
						live_q[row_idx][r] <= shadow_q[row_idx][r];
					end
				end
				default: ;
			endcase
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q <= (dec_s1.op == OP_READ) ? DATA_W'(live_val) : '0;
			bad_q       <= (dec_s1.op == OP_BAD);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_data  = read_data_q;
	assign rsp.bad_access = bad_q;

endmodule

`default_nettype wire

>>> design/gpf_checker.sv
// Port-level checker for the pad-function block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gpf_checker import gpf_pkg::*; #(
	parameter int PINS_PER_PORT = 32
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [DATA_W-1:0] rsp_read_data,
	input logic              rsp_bad_access
);

	// A stalled response stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// A refused access never returns data.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_bad_access |-> rsp_read_data == '0)
		else $error("refused access returned data");

	// Bits above the last pin read as zero.
	a_pin_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_read_data >> PINS_PER_PORT) == '0)
		else $error("read data beyond the pin range");

	// With no response pending, an accepted request is answered once the response register is then empty or being taken.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid ##1 (rsp_ready || !rsp_valid) |=> rsp_valid)
		else $error("response missing after request");

endmodule

bind gpio_pad_function_port_unit gpf_checker #(
	.PINS_PER_PORT (PINS_PER_PORT)
) u_gpf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_data  (rsp.read_data),
	.rsp_bad_access (rsp.bad_access)
);

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the pad-function register block, with its scoreboard and stimulus.
`timescale 1ns / 1ps

module tb;
	import gpf_pkg::*;

	localparam int N_PORTS      = 4;
	localparam int N_PINS       = 32;
	localparam int RANDOM_ITEMS = 1325;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [63:0]       PIN_MASK_WIDE = (64'd1 << N_PINS) - 64'd1;
	localparam logic [DATA_W-1:0] PIN_MASK      = PIN_MASK_WIDE[DATA_W-1:0];

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              bad_access;
	} access_result_t;

	// Mirror of the live and shadow registers plus the queue of responses still owed.
	class pad_reg_scoreboard;
		logic [DATA_W-1:0] live_copy[16];
		logic [DATA_W-1:0] shadow_copy[16];
		access_result_t    pending_results[$];
		int                errors;

		function new();
			for (int p = 0; p < 4; p++) begin
				live_copy[p*NUM_REGS + int'(REG_INT)]   = '0;
				live_copy[p*NUM_REGS + int'(REG_MSK)]   = PIN_MASK;
				live_copy[p*NUM_REGS + int'(REG_PTRN1)] = PIN_MASK;
				live_copy[p*NUM_REGS + int'(REG_PTRN0)] = '0;
			end
			shadow_copy = live_copy;
			errors = 0;
		endfunction

		// Maps a base offset to its register; returns 0 when the offset is not a base.
		function bit base_reg(offset_t off, output reg_sel_t sel);
			sel = REG_INT;
			case (off)
				OFF_INT:  sel = REG_INT;
				OFF_MSK:  sel = REG_MSK;
				OFF_PAT1: sel = REG_PTRN1;
				OFF_PAT0: sel = REG_PTRN0;
				default:  return 1'b0;
			endcase
			return 1'b1;
		endfunction

		function op_t decode_access(logic kind, logic [ADDR_W-1:0] address,
				logic [DATA_W-1:0] wdata, output reg_sel_t sel);
			offset_t off;
			int      port;
			off  = address[ADDR_OFF_W-1:0];
			port = int'(address[ADDR_W-1:ADDR_OFF_W]);
			sel  = REG_INT;
			if (port >= N_PORTS)
				return OP_BAD;
			if (!kind)
				return base_reg(off, sel) ? OP_READ : OP_BAD;
			if (off == OFF_COMMIT)
				return (wdata < N_PORTS) ? OP_COMMIT : OP_BAD;
			if (off >= ALIAS_SET && base_reg(off - ALIAS_SET, sel))
				return OP_SET;
			if (off >= ALIAS_CLR && base_reg(off - ALIAS_CLR, sel))
				return OP_CLR;
			return OP_BAD;
		endfunction

		// Applies an accepted request to the mirror and queues the response it owes.
		function void note_access(logic kind, logic [ADDR_W-1:0] address,
				logic [DATA_W-1:0] wdata);
			reg_sel_t       sel;
			op_t            op;
			int             idx;
			int             target;
			access_result_t res;
			op  = decode_access(kind, address, wdata, sel);
			idx = int'(address[ADDR_W-1:ADDR_OFF_W]) * NUM_REGS + int'(sel);
			res.read_data  = '0;
			res.bad_access = (op == OP_BAD);
			case (op)
				OP_READ: res.read_data = live_copy[idx] & PIN_MASK;
				OP_SET:  shadow_copy[idx] = shadow_copy[idx] | (wdata & PIN_MASK);
				OP_CLR:  shadow_copy[idx] = shadow_copy[idx] & ~(wdata & PIN_MASK);
				OP_COMMIT: begin
					target = int'(wdata[1:0]);
					for (int r = 0; r < NUM_REGS; r++)
						live_copy[target*NUM_REGS + r] = shadow_copy[target*NUM_REGS + r];
				end
				default: ;
			endcase
			pending_results.push_back(res);
		endfunction

		function void check_response(logic [DATA_W-1:0] read_data, logic bad_access);
			access_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response read_data=%h bad_access=%b",
					$time, read_data, bad_access);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (read_data !== want.read_data) begin
				$display("%0t: read_data expected %h actual %h", $time, want.read_data, read_data);
				errors++;
			end
			if (bad_access !== want.bad_access) begin
				$display("%0t: bad_access expected %b actual %b",
					$time, want.bad_access, bad_access);
				errors++;
			end
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count    = 0;
	int   responses_seen = 0;
	int   burst_left     = 0;

	pad_reg_scoreboard sb = new();

	gpf_req_if req();
	gpf_rsp_if rsp();

	gpio_pad_function_port_unit #(
		.NUM_PORTS    (N_PORTS),
		.PINS_PER_PORT(N_PINS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	// Offers one request transaction, waits for its acceptance and then idles at random.
	task automatic send_access(input logic kind, input logic [ADDR_W-1:0] address,
			input logic [DATA_W-1:0] wdata);
		int gap;
		req.valid      <= 1'b1;
		req.kind       <= kind;
		req.address    <= address;
		req.write_data <= wdata;
		do @(posedge clk); while (!req.ready);
		sb.note_access(kind, address, wdata);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 99) < 3) begin
			burst_left = $urandom_range(30, 60);
			gap = 0;
		end else begin
			gap = idle_length();
		end
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic [DATA_W-1:0] pin_pattern();
		case ($urandom_range(0, 4))
			0:       return DATA_W'(1) << $urandom_range(0, DATA_W-1);
			1:       return ~(DATA_W'(1) << $urandom_range(0, DATA_W-1));
			2:       return $urandom_range(0, 1) ? '1 : '0;
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed set, clear, commit and read sequences, the rest noise.
	task automatic send_random_access();
		offset_t                bases[4];
		logic [ADDR_PORT_W-1:0] port;
		offset_t                off;
		logic [DATA_W-1:0]      wdata;
		logic                   kind;
		int                     r;
		bases = '{OFF_INT, OFF_MSK, OFF_PAT1, OFF_PAT0};
		port  = ADDR_PORT_W'($urandom_range(0, N_PORTS-1));
		off   = bases[$urandom_range(0, 3)];
		wdata = pin_pattern();
		kind  = 1'b1;
		r     = $urandom_range(0, 99);
		if (r < 33) begin
			kind  = 1'b0;
			wdata = $urandom;
		end else if (r < 53) begin
			off = off + ALIAS_SET;
		end else if (r < 73) begin
			off = off + ALIAS_CLR;
		end else if (r < 85) begin
			off   = OFF_COMMIT;
			wdata = ($urandom_range(0, 9) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(0, 3));
		end else if (r < 92) begin
			// Near misses just above a mapped offset, as a read or a write.
			kind = 1'($urandom_range(0, 1));
			off  = off + offset_t'($urandom_range(1, 15));
		end else begin
			kind  = 1'($urandom_range(0, 1));
			port  = ADDR_PORT_W'($urandom);
			off   = offset_t'($urandom);
			wdata = $urandom;
		end
		send_access(kind, {port, off}, wdata);
	endtask

	// Response monitor: every accepted response goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			sb.check_response(rsp.read_data, rsp.bad_access);
			responses_seen++;
		end
	end

	// Response sink: random ready, stretches without idling, and one long hold-off.
	initial begin
		int  run;
		int  gap;
		bit  held;
		held = 1'b0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && responses_seen >= 400) begin
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			run = ($urandom_range(0, 19) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 20);
			rsp.ready <= 1'b1;
			repeat (run) @(negedge clk);
			gap = idle_length();
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: done, errors");
		$finish;
	end

	// Reset, directed accesses, random accesses, then drain and report.
	initial begin
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.kind       = 1'b0;
		req.address    = '0;
		req.write_data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Reset values of port 0.
		send_access(1'b0, 14'h0010, '0);
		send_access(1'b0, 14'h0020, '0);
		send_access(1'b0, 14'h0030, '0);
		send_access(1'b0, 14'h0040, '1);
		// A set stays in the shadow copy until the port is committed.
		send_access(1'b1, 14'h0014, '1);
		send_access(1'b0, 14'h0010, '0);
		send_access(1'b1, 14'h00F0, 32'd0);
		send_access(1'b0, 14'h0010, '0);
		// Clears and sets on other registers, committed through another port's address.
		send_access(1'b1, 14'h0028, 32'h0000_FFFF);
		send_access(1'b1, 14'h0038, '1);
		send_access(1'b1, 14'h0044, 32'hA5A5_A5A5);
		send_access(1'b1, 14'h10F0, 32'd0);
		send_access(1'b0, 14'h0020, '0);
		send_access(1'b0, 14'h0040, '0);
		// Commit naming a port that does not exist.
		send_access(1'b1, 14'h00F0, 32'd4);
		send_access(1'b1, 14'h00F0, '1);
		// Reads of an alias and of the commit offset, and a plain write to a base offset.
		send_access(1'b0, 14'h0014, '0);
		send_access(1'b0, 14'h00F0, '0);
		send_access(1'b1, 14'h0010, 32'd1);
		// Unmapped offsets at the ends of the address range.
		send_access(1'b0, 14'h0000, '0);
		send_access(1'b1, 14'h3FFF, '1);
		send_access(1'b0, 14'h3FFF, '0);
		// Last port: clear, commit and read back.
		send_access(1'b1, 14'h3048, '1);
		send_access(1'b1, 14'h30F0, 32'd3);
		send_access(1'b0, 14'h3040, '0);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_random_access();
		req.valid <= 1'b0;

		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

>>> sim.f
design/gpf_pkg.sv
design/gpf_req_if.sv
design/gpf_rsp_if.sv
design/gpf_decode.sv
design/gpio_pad_function_port_unit.sv
design/gpf_checker.sv
verif/tb.sv
